// ===== rtl/cffc_pkg.sv =====
// ----------------------------------------------------------------------------
// cffc_pkg
// Shared types, codes and the CRC-32 byte update for the framed file checker.
// ----------------------------------------------------------------------------
package cffc_pkg;

  localparam int unsigned HdrLen    = 12;
  localparam int unsigned HdrBits   = HdrLen * 8;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes   = 32'hFFFF_FFFF;
  localparam logic [15:0] HdrSizeOk = 16'd12;
  localparam logic [3:0]  HdrLastIx = 4'd11;

  // configuration register indexes
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_BAD_HSIZE = 3'd4,
    ST_TRUNC     = 3'd5,
    ST_CRC_BAD   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_CRC     = 4'b0100,
    PH_TAIL    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] payload_length;
    logic [31:0] computed_crc;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cffc_in_stage.sv =====
// ----------------------------------------------------------------------------
// cffc_in_stage
// Input register: holds one byte request until the checker core takes it.
// ----------------------------------------------------------------------------
module cffc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cffc_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_take,
  output cffc_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  cffc_pkg::item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/cffc_core.sv =====
// ----------------------------------------------------------------------------
// cffc_core
// Header check, payload CRC, stored CRC compare and the result register.
// ----------------------------------------------------------------------------
module cffc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic             item_valid,
  output logic             item_take,
  input  cffc_pkg::item_t  item,
  output logic             res_valid,
  input  logic             res_ready,
  output cffc_pkg::result_t res
);

  logic [31:0]                   magic_r;
  logic [15:0]                   version_r;

  cffc_pkg::phase_t              phase_r, phase_nxt;
  logic [31:0]                   cnt_r, cnt_nxt;
  logic [cffc_pkg::HdrBits-1:0]  hdr_r, hdr_nxt;
  logic [31:0]                   len_r, len_nxt;
  logic [31:0]                   crc_r, crc_nxt;
  logic [31:0]                   scrc_r, scrc_nxt;
  cffc_pkg::status_t             err_r, err_nxt;
  logic [31:0]                   cnt_inc;

  logic                          out_v_r;
  cffc_pkg::result_t             out_r;
  cffc_pkg::result_t             out_nxt;
  logic                          slot_free;
  logic                          fin;

  assign slot_free = !out_v_r || res_ready;
  assign item_take = item_valid && (!item.last_byte || slot_free);
  assign fin       = item_take && item.last_byte;
  assign res_valid = out_v_r;
  assign res       = out_r;
  assign cnt_inc   = cnt_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      version_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cffc_pkg::REG_MAGIC:   magic_r   <= cfg_wdata;
        cffc_pkg::REG_VERSION: version_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    scrc_nxt  = scrc_r;
    err_nxt   = err_r;
    case (phase_r)
      cffc_pkg::PH_HEADER: begin
        hdr_nxt = {item.file_byte, hdr_r[cffc_pkg::HdrBits-1:8]};
        cnt_nxt = cnt_inc;
        if (cnt_r[3:0] == cffc_pkg::HdrLastIx) begin
          cnt_nxt = '0;
          len_nxt = hdr_nxt[95:64];
          if (hdr_nxt[31:0] != magic_r) begin
            err_nxt   = cffc_pkg::ST_BAD_MAGIC;
            phase_nxt = cffc_pkg::PH_TAIL;
          end else if (hdr_nxt[47:32] != version_r) begin
            err_nxt   = cffc_pkg::ST_BAD_VER;
            phase_nxt = cffc_pkg::PH_TAIL;
          end else if (hdr_nxt[63:48] != cffc_pkg::HdrSizeOk) begin
            err_nxt   = cffc_pkg::ST_BAD_HSIZE;
            phase_nxt = cffc_pkg::PH_TAIL;
          end else if (hdr_nxt[95:64] == 32'd0) begin
            phase_nxt = cffc_pkg::PH_CRC;
          end else begin
            phase_nxt = cffc_pkg::PH_PAYLOAD;
          end
        end
      end
      cffc_pkg::PH_PAYLOAD: begin
        crc_nxt = cffc_pkg::crc_byte(crc_r, item.file_byte);
        cnt_nxt = cnt_inc;
        if (cnt_inc == len_r) begin
          cnt_nxt   = '0;
          phase_nxt = cffc_pkg::PH_CRC;
        end
      end
      cffc_pkg::PH_CRC: begin
        scrc_nxt = scrc_r | ({24'd0, item.file_byte} << {cnt_r[1:0], 3'b000});
        cnt_nxt  = cnt_inc;
        if (cnt_r[1:0] == 2'd3) begin
          if ((crc_r ^ cffc_pkg::CrcOnes) != scrc_nxt) begin
            err_nxt = cffc_pkg::ST_CRC_BAD;
          end
          phase_nxt = cffc_pkg::PH_TAIL;
        end
      end
      default: ;
    endcase

    out_nxt.computed_crc = crc_nxt ^ cffc_pkg::CrcOnes;
    case (phase_nxt)
      cffc_pkg::PH_HEADER: begin
        out_nxt.status         = cffc_pkg::ST_TOO_SHORT;
        out_nxt.payload_length = '0;
      end
      cffc_pkg::PH_PAYLOAD, cffc_pkg::PH_CRC: begin
        out_nxt.status         = cffc_pkg::ST_TRUNC;
        out_nxt.payload_length = len_nxt;
      end
      default: begin
        out_nxt.status         = err_nxt;
        out_nxt.payload_length = len_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cffc_pkg::PH_HEADER;
      cnt_r   <= '0;
      crc_r   <= cffc_pkg::CrcOnes;
      scrc_r  <= '0;
      err_r   <= cffc_pkg::ST_OK;
      out_v_r <= 1'b0;
    end else begin
      if (item_take) begin
        if (item.last_byte) begin
          phase_r <= cffc_pkg::PH_HEADER;
          cnt_r   <= '0;
          crc_r   <= cffc_pkg::CrcOnes;
          scrc_r  <= '0;
          err_r   <= cffc_pkg::ST_OK;
        end else begin
          phase_r <= phase_nxt;
          cnt_r   <= cnt_nxt;
          crc_r   <= crc_nxt;
          scrc_r  <= scrc_nxt;
          err_r   <= err_nxt;
        end
      end
      if (fin) begin
        out_v_r <= 1'b1;
      end else if (res_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      hdr_r <= hdr_nxt;
      len_r <= len_nxt;
    end
    if (fin) begin
      out_r <= out_nxt;
    end
  end

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status == cffc_pkg::ST_TOO_SHORT |->
      out_r.payload_length == 32'd0 && out_r.computed_crc == 32'd0)
    else $error("short file result carries nonzero fields");

  a_hdr_fail_nocrc: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.status == cffc_pkg::ST_BAD_MAGIC ||
                out_r.status == cffc_pkg::ST_BAD_VER ||
                out_r.status == cffc_pkg::ST_BAD_HSIZE) |->
      out_r.computed_crc == 32'd0)
    else $error("header failure with payload CRC");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> phase_r == cffc_pkg::PH_HEADER && cnt_r == 32'd0 &&
            crc_r == cffc_pkg::CrcOnes && err_r == cffc_pkg::ST_OK)
    else $error("checker did not re-arm after final byte");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cffc_pkg::PH_HEADER |-> cnt_r < 32'd12)
    else $error("header byte count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_ready |=> out_v_r && $stable(out_r))
    else $error("pending result lost or changed");

endmodule

// ===== rtl/crc32_framed_file_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc32_framed_file_checker_top
// Streaming checker for files with a 12-byte header and a CRC-32 payload.
// ----------------------------------------------------------------------------
// One file byte is taken per clock with no gaps, including across file
// boundaries; the per-byte CRC-32 update and header compare are combinational
// logic after the input register. The final byte of a file (tlast) yields
// one result, valid in the cycle after its request is taken, held in an
// output register so input keeps flowing while the result waits; only a final
// byte stalls when a previous result is still pending. Configure magic and
// version only between files.
module crc32_framed_file_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [2:0] status, [34:3] payload_length,
                                  // [66:35] computed_crc, [71:67] zero
);

  cffc_pkg::item_t   in_item;
  cffc_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  cffc_pkg::result_t res;

  assign in_item.file_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  cffc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  cffc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {5'd0, res.computed_crc, res.payload_length, res.status};

endmodule
